// ===== hw/rtl/wstm_pkg.sv =====
// shared widths, constants and the cell control bundle of the window sum target matcher
`timescale 1ns / 1ps

package wstm_pkg;

    localparam int VALUE_W    = 8;   // sample width
    localparam int TARGET_W   = 12;  // target register width
    localparam int SUM_W      = 13;  // running window sum width
    localparam int OUT_IDX_W  = 16;  // index width on the result beat
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register map, decoded on the word address bit
    localparam logic REG_TARGET = 1'b0;

    localparam logic [TARGET_W-1:0] TARGET_RESET = 12'd10;

    // per-cell control from the sequencer
    typedef struct packed {
        logic accept;    // new sample: add it to the window sum
        logic pop;       // scan step: take the upper neighbor's content
        logic clear;     // end of sequence: close every window
        logic load_new;  // this cell opens the new window
        logic load_ret;  // this cell takes the window kept from cell 0
    } t_cell_ctl;

endpackage

// ===== hw/rtl/wstm_cell.sv =====
// one window cell: start index, running sum and open bit, shifting toward cell 0
`timescale 1ns / 1ps

module wstm_cell #(
    parameter int INDEX_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  wstm_pkg::t_cell_ctl               i_ctl,
    input  logic [wstm_pkg::VALUE_W-1:0]      i_value,
    input  logic [INDEX_BITS-1:0]             i_here,
    input  logic [wstm_pkg::TARGET_W-1:0]     i_target,
    input  logic                              i_up_vld,
    input  logic [INDEX_BITS-1:0]             i_up_start,
    input  logic [wstm_pkg::SUM_W-1:0]        i_up_sum,
    input  logic [INDEX_BITS-1:0]             i_ret_start,
    input  logic [wstm_pkg::SUM_W-1:0]        i_ret_sum,
    output logic                              o_vld,
    output logic [INDEX_BITS-1:0]             o_start,
    output logic [wstm_pkg::SUM_W-1:0]        o_sum,
    output logic                              o_hit,
    output logic                              o_keep
);

    localparam int SW = wstm_pkg::SUM_W;

    logic                 r_vld;
    logic [INDEX_BITS-1:0] r_start;
    logic [SW-1:0]        r_sum;
    logic [SW-1:0]        w_target;

    assign w_target = SW'(i_target);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.clear) begin
            r_vld <= 1'b0;
        end else if (i_ctl.accept) begin
            if (i_ctl.load_new) begin
                r_vld <= 1'b1;
            end
        end else if (i_ctl.pop) begin
            r_vld <= i_ctl.load_ret | i_up_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            if (i_ctl.load_new) begin
                r_start <= i_here;
                r_sum   <= SW'(i_value);
            end else begin
                r_sum   <= r_sum + SW'(i_value);
            end
        end else if (i_ctl.pop) begin
            if (i_ctl.load_ret) begin
                r_start <= i_ret_start;
                r_sum   <= i_ret_sum;
            end else begin
                r_start <= i_up_start;
                r_sum   <= i_up_sum;
            end
        end
    end

    assign o_vld   = r_vld;
    assign o_start = r_start;
    assign o_sum   = r_sum;
    assign o_hit   = r_vld && (r_sum == w_target);
    assign o_keep  = r_vld && (r_sum < w_target);

endmodule

// ===== hw/rtl/window_sum_target_matcher.sv =====
// window sum target matcher: row of window cells, scan sequencer, result register, apb target
`timescale 1ns / 1ps
// order: a sample is accepted, then cell 0 is popped once per open window plus once for the
//   new window unless the row is full; a match is on the result port the cycle after its pop
// pacing: a new sample is taken only once the scan of the last one is done, paced by the
//   single pop-and-requeue step at cell 0; a held result beat stalls the scan
// reset: synchronous active low; all windows closed, index and lost flag zero, target 10

module window_sum_target_matcher #(
    parameter int OPEN_WINDOWS = 32,
    parameter int INDEX_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] sample_value
    input  logic        i_s_axis_tlast,   // end_of_sequence
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [15:0] window_start, [31:16] window_end
    output logic        o_m_axis_tlast,   // last_of_run
    output logic [0:0]  o_m_axis_tuser,   // [0] windows_lost
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int OW    = wstm_pkg::OUT_IDX_W;
    localparam int SW    = wstm_pkg::SUM_W;
    localparam int TW    = wstm_pkg::TARGET_W;
    localparam int DW    = wstm_pkg::APB_DATA_W;
    localparam int CNT_W = $clog2(OPEN_WINDOWS + 1);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(OPEN_WINDOWS);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    // sequencer states
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    // control and configuration
    logic                  r_state;
    logic [CNT_W-1:0]      r_cnt;    // open windows, packed from cell 0
    logic [CNT_W-1:0]      r_left;   // windows still to pop this sample
    logic [CNT_W-1:0]      r_tail;   // valid cells during the scan
    logic [INDEX_BITS-1:0] r_next;
    logic [INDEX_BITS-1:0] r_here;
    logic                  r_eos;
    logic                  r_lost;
    logic [TW-1:0]         r_target;

    // result register
    logic                  r_ovld;
    logic [OW-1:0]         r_ostart;
    logic [OW-1:0]         r_oend;
    logic                  r_olast;
    logic                  r_olost;  // lost flag as it stood for this beat's sample

    // cell row
    logic [OPEN_WINDOWS-1:0] w_vld;
    logic [OPEN_WINDOWS-1:0] w_hit;
    logic [OPEN_WINDOWS-1:0] w_keep;
    logic [OPEN_WINDOWS-1:0] w_pack_mask;
    logic [INDEX_BITS-1:0]   w_start [OPEN_WINDOWS];
    logic [SW-1:0]           w_sum   [OPEN_WINDOWS];
    wstm_pkg::t_cell_ctl     w_ctl   [OPEN_WINDOWS];

    logic             w_accept;
    logic             w_full;
    logic             w_pop;
    logic             w_last_pop;
    logic             w_more_hits;
    logic [CNT_W-1:0] w_tail_m1;
    logic [CNT_W-1:0] n_tail;
    logic [CNT_W-1:0] n_first;
    logic             w_cfg_wr;

    // accept only between scans; the result register decouples the output side
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_full          = (r_cnt == FULL_CNT);

    // one pop per cycle unless a result beat is held
    assign w_pop      = (r_state == ST_SCAN) && (!r_ovld || i_m_axis_tready);
    assign w_last_pop = w_pop && (r_left == ONE_CNT);

    // a further match anywhere above cell 0 means this one is not the last
    assign w_more_hits = |(w_hit >> 1);

    // kept windows requeue at the top of the valid run after the shift
    assign w_tail_m1 = r_tail - ONE_CNT;
    assign n_tail    = w_keep[0] ? r_tail : w_tail_m1;

    // the new window joins the scan unless the row is full
    assign n_first = w_full ? FULL_CNT : r_cnt + ONE_CNT;

    genvar gi;
    generate
        for (gi = 0; gi < OPEN_WINDOWS; gi++) begin : g_cell
            logic                  w_up_vld;
            logic [INDEX_BITS-1:0] w_up_start;
            logic [SW-1:0]         w_up_sum;

            if (gi == OPEN_WINDOWS - 1) begin : g_top
                assign w_up_vld   = 1'b0;
                assign w_up_start = '0;
                assign w_up_sum   = '0;
            end else begin : g_mid
                assign w_up_vld   = w_vld[gi+1];
                assign w_up_start = w_start[gi+1];
                assign w_up_sum   = w_sum[gi+1];
            end

            assign w_ctl[gi].accept   = w_accept;
            assign w_ctl[gi].pop      = w_pop;
            assign w_ctl[gi].clear    = w_last_pop && r_eos;
            assign w_ctl[gi].load_new = w_accept && !w_full && (r_cnt == CNT_W'(gi));
            assign w_ctl[gi].load_ret = w_pop && w_keep[0] && (w_tail_m1 == CNT_W'(gi));

            assign w_pack_mask[gi] = (CNT_W'(gi) < r_cnt);

            wstm_cell #(
                .INDEX_BITS (INDEX_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl[gi]),
                .i_value     (i_s_axis_tdata),
                .i_here      (r_next),
                .i_target    (r_target),
                .i_up_vld    (w_up_vld),
                .i_up_start  (w_up_start),
                .i_up_sum    (w_up_sum),
                .i_ret_start (w_start[0]),
                .i_ret_sum   (w_sum[0]),
                .o_vld       (w_vld[gi]),
                .o_start     (w_start[gi]),
                .o_sum       (w_sum[gi]),
                .o_hit       (w_hit[gi]),
                .o_keep      (w_keep[gi])
            );
        end
    endgenerate

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_left  <= '0;
            r_tail  <= '0;
            r_next  <= '0;
            r_eos   <= 1'b0;
            r_lost  <= 1'b0;
        end else if (w_accept) begin
            r_state <= ST_SCAN;
            r_left  <= n_first;
            r_tail  <= n_first;
            r_eos   <= i_s_axis_tlast;
            r_next  <= i_s_axis_tlast ? '0 : r_next + INDEX_BITS'(1);
            if (w_full) begin
                r_lost <= 1'b1;     // sticky until reset
            end
        end else if (w_pop) begin
            r_left <= r_left - ONE_CNT;
            r_tail <= n_tail;
            if (w_last_pop) begin
                r_state <= ST_IDLE;
                r_cnt   <= r_eos ? '0 : n_tail;
            end
        end
    end

    // index of the sample under scan
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_here <= r_next;
        end
    end

    // result register: loaded by a matching pop, freed when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_pop && w_hit[0]) begin
            r_ovld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && w_hit[0]) begin
            r_ostart <= OW'(w_start[0]);
            r_oend   <= OW'(r_here);
            r_olast  <= !w_more_hits;
            r_olost  <= r_lost;
        end
    end

    assign o_m_axis_tvalid   = r_ovld;
    assign o_m_axis_tdata    = {r_oend, r_ostart};
    assign o_m_axis_tlast    = r_olast;
    assign o_m_axis_tuser[0] = r_olost;

    // register port
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= wstm_pkg::TARGET_RESET;
        end else if (w_cfg_wr && (paddr[2] == wstm_pkg::REG_TARGET)) begin
            r_target <= pwdata[TW-1:0];
        end
    end

    assign prdata = (paddr[2] == wstm_pkg::REG_TARGET) ? DW'(r_target) : '0;
    assign pready = 1'b1;

`ifndef SYNTHESIS
    // requeued windows never outrun the ones still to pop
    a_tail_covers_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_tail >= r_left))
        else $error("scan tail below remaining count");

    // between samples the open cells form a packed run from cell 0
    a_packed_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (w_vld == w_pack_mask))
        else $error("open cells not packed");

    // every pop takes a real window out of cell 0
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_vld[0])
        else $error("pop of an empty cell");

    // the window count never exceeds the row
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("window count out of range");
`endif

endmodule

// ===== bench/window_sum_target_matcher_test.sv =====
// self-checking testbench for the window sum target matcher
`timescale 1ns / 1ps

module window_sum_target_matcher_test;

    localparam int VALUE_W    = wstm_pkg::VALUE_W;
    localparam int TARGET_W   = wstm_pkg::TARGET_W;
    localparam int SUM_W      = wstm_pkg::SUM_W;
    localparam int OUT_IDX_W  = wstm_pkg::OUT_IDX_W;
    localparam int APB_ADDR_W = wstm_pkg::APB_ADDR_W;
    localparam int APB_DATA_W = wstm_pkg::APB_DATA_W;
    localparam logic REG_TARGET = wstm_pkg::REG_TARGET;

    localparam int OPEN_WINDOWS   = 32;
    localparam int INDEX_BITS     = 16;
    // settle time after the last expected beat, longer than a full scan of every cell
    localparam int SETTLE_CYCLES  = 2 * (OPEN_WINDOWS + 2) + 8;
    // cycles without any beat before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 40;

    // target value the block must come up with
    localparam logic [TARGET_W-1:0] TARGET_AFTER_RESET = 12'd10;
    // word index with no register behind it
    localparam logic REG_SPARE = 1'b1;

    // how a directed row is checked
    typedef enum logic [1:0] {
        ROW_PREDICT,  // predictor supplies the expected windows
        ROW_QUIET,    // no window may match
        ROW_MATCH,    // exactly one window, given in the row
        ROW_WRITE     // register write between samples
    } t_row_kind;

    // receiver stall patterns
    typedef enum logic [1:0] {
        SINK_OPEN,    // always ready
        SINK_COIN,    // ready half the time
        SINK_SPARSE,  // ready one cycle in four
        SINK_HOLD     // stalled for the whole stretch
    } t_sink_mode;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] win_start;
        logic [OUT_IDX_W-1:0] win_end;
        logic                 run_last;
        logic                 lost;
    } t_window;

    typedef struct packed {
        t_row_kind              kind;
        logic [VALUE_W-1:0]     value;
        logic                   eos;
        logic [OUT_IDX_W-1:0]   exp_start;
        logic [OUT_IDX_W-1:0]   exp_end;
        logic                   reg_index;
        logic [APB_DATA_W-1:0]  reg_data;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 24;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;

    logic                  sample_tvalid = 1'b0;
    logic                  sample_tready;
    logic [7:0]            sample_tdata = '0;
    logic                  sample_tlast = 1'b0;

    logic                  result_tvalid;
    logic                  result_tready = 1'b0;
    logic [31:0]           result_tdata;
    logic                  result_tlast;
    logic [0:0]            result_tuser;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // expected matches, oldest first
    t_window expected_windows[$];
    int      fail_count = 0;
    int      idle_cycles = 0;
    int      burst_left = 0;

    // predictor copy of the window row
    logic [OUT_IDX_W-1:0] cell_from  [OPEN_WINDOWS];
    logic [SUM_W-1:0]     cell_total [OPEN_WINDOWS];
    int                   open_cells = 0;
    logic [OUT_IDX_W-1:0] index_now = '0;
    logic                 lost_seen = 1'b0;
    logic [TARGET_W-1:0]  target_now = TARGET_AFTER_RESET;

    // directed part: extremes, typed matches, target changes with windows open
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        // single-element window at index 0
        '{ROW_MATCH,   8'd10,  1'b0, 16'd0, 16'd0, REG_TARGET, 32'd0},
        '{ROW_QUIET,   8'd0,   1'b0, 16'd0, 16'd0, REG_TARGET, 32'd0},
        // overshoot closes both open windows silently
        '{ROW_QUIET,   8'd255, 1'b0, 16'd0, 16'd0, REG_TARGET, 32'd0},
        '{ROW_QUIET,   8'd4,   1'b0, 16'd0, 16'd0, REG_TARGET, 32'd0},
        '{ROW_MATCH,   8'd6,   1'b0, 16'd3, 16'd4, REG_TARGET, 32'd0},
        '{ROW_MATCH,   8'd4,   1'b0, 16'd4, 16'd5, REG_TARGET, 32'd0},
        // end of sequence with windows still open
        '{ROW_QUIET,   8'd3,   1'b1, 16'd0, 16'd0, REG_TARGET, 32'd0},
        // several windows close on one sample
        '{ROW_PREDICT, 8'd0,   1'b0, 16'd0, 16'd0, REG_TARGET, 32'd0},
        '{ROW_PREDICT, 8'd0,   1'b0, 16'd0, 16'd0, REG_TARGET, 32'd0},
        '{ROW_PREDICT, 8'd0,   1'b0, 16'd0, 16'd0, REG_TARGET, 32'd0},
        '{ROW_PREDICT, 8'd10,  1'b0, 16'd0, 16'd0, REG_TARGET, 32'd0},
        '{ROW_PREDICT, 8'd7,   1'b1, 16'd0, 16'd0, REG_TARGET, 32'd0},
        // target of zero: a zero sample matches at once
        '{ROW_WRITE,   8'd0,   1'b0, 16'd0, 16'd0, REG_TARGET, 32'd0},
        '{ROW_MATCH,   8'd0,   1'b0, 16'd0, 16'd0, REG_TARGET, 32'd0},
        '{ROW_PREDICT, 8'd1,   1'b0, 16'd0, 16'd0, REG_TARGET, 32'd0},
        '{ROW_PREDICT, 8'd0,   1'b1, 16'd0, 16'd0, REG_TARGET, 32'd0},
        // write to the unused word must leave the target alone
        '{ROW_WRITE,   8'd0,   1'b0, 16'd0, 16'd0, REG_SPARE,  32'hFFFF_FFFF},
        '{ROW_WRITE,   8'd0,   1'b0, 16'd0, 16'd0, REG_TARGET, 32'hFFFF_FFFF},
        '{ROW_PREDICT, 8'd255, 1'b0, 16'd0, 16'd0, REG_TARGET, 32'd0},
        '{ROW_PREDICT, 8'd255, 1'b0, 16'd0, 16'd0, REG_TARGET, 32'd0},
        '{ROW_PREDICT, 8'd3,   1'b0, 16'd0, 16'd0, REG_TARGET, 32'd0},
        // lower target while windows are open
        '{ROW_WRITE,   8'd0,   1'b0, 16'd0, 16'd0, REG_TARGET, 32'd5},
        '{ROW_PREDICT, 8'd1,   1'b0, 16'd0, 16'd0, REG_TARGET, 32'd0},
        '{ROW_PREDICT, 8'd4,   1'b1, 16'd0, 16'd0, REG_TARGET, 32'd0}
    };

    window_sum_target_matcher #(
        .OPEN_WINDOWS (OPEN_WINDOWS),
        .INDEX_BITS   (INDEX_BITS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (sample_tvalid),
        .o_s_axis_tready (sample_tready),
        .i_s_axis_tdata  (sample_tdata),   // [7:0] sample_value
        .i_s_axis_tlast  (sample_tlast),   // end_of_sequence
        .o_m_axis_tvalid (result_tvalid),
        .i_m_axis_tready (result_tready),
        .o_m_axis_tdata  (result_tdata),   // [15:0] window_start, [31:16] window_end
        .o_m_axis_tlast  (result_tlast),   // last_of_run
        .o_m_axis_tuser  (result_tuser),   // [0] windows_lost
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // one sample through the window row: open a window, add, close matches and overshoots
    function automatic void predict_windows(input logic [VALUE_W-1:0] value, input logic eos,
                                            ref t_window found[$]);
        int                   kept;
        logic [SUM_W-1:0]     total;
        logic [OUT_IDX_W-1:0] here;
        t_window              hit;
        here = index_now;
        kept = 0;
        found.delete();
        // no free cell: the new window is dropped and the sticky flag goes up first
        if (open_cells < OPEN_WINDOWS) begin
            cell_from[open_cells]  = here;
            cell_total[open_cells] = '0;
            open_cells++;
        end else begin
            lost_seen = 1'b1;
        end
        for (int k = 0; k < open_cells; k++) begin
            total = cell_total[k] + value;
            if (total == SUM_W'(target_now)) begin
                hit = '{win_start: cell_from[k], win_end: here,
                        run_last: 1'b0, lost: lost_seen};
                found = {found, hit};
            end else if (total < SUM_W'(target_now)) begin
                // survivors stay packed at the low end in opening order
                cell_from[kept]  = cell_from[k];
                cell_total[kept] = total;
                kept++;
            end
        end
        open_cells = kept;
        if (found.size() > 0) found[found.size() - 1].run_last = 1'b1;
        if (eos) begin
            open_cells = 0;
            index_now  = '0;
        end else begin
            index_now = here + 16'd1;  // wraps at the index width
        end
    endfunction

    // mostly small values so windows actually reach the target
    function automatic logic [VALUE_W-1:0] pick_value(input logic [TARGET_W-1:0] target);
        int hi;
        int roll;
        hi = (target < 4) ? 3 : target / 3;
        if (hi > 255) hi = 255;
        roll = $urandom_range(0, 99);
        if (roll < 10) return '0;
        if (roll < 80) return VALUE_W'($urandom_range(0, hi));
        if (roll < 94) return VALUE_W'($urandom_range(0, 255));
        return 8'hFF;
    endfunction

    // sender: bursts of random length with random gaps in between
    task automatic send_sample(input t_row_kind kind, input logic [VALUE_W-1:0] value,
                               input logic eos, input logic [OUT_IDX_W-1:0] exp_start,
                               input logic [OUT_IDX_W-1:0] exp_end);
        t_window found[$];
        t_window typed;
        int      gap;
        predict_windows(value, eos, found);
        case (kind)
            ROW_QUIET: begin
            end
            ROW_MATCH: begin
                typed = '{win_start: exp_start, win_end: exp_end,
                          run_last: 1'b1, lost: 1'b0};
                expected_windows = {expected_windows, typed};
            end
            default: begin
                foreach (found[i]) expected_windows = {expected_windows, found[i]};
            end
        endcase
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                sample_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        sample_tvalid <= 1'b1;
        sample_tdata  <= value;
        sample_tlast  <= eos;
        @(posedge i_clk);
        while (!sample_tready) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic feed_sample(input logic [VALUE_W-1:0] value, input logic eos);
        send_sample(ROW_PREDICT, value, eos, '0, '0);
    endtask

    // drop valid, let every expected beat arrive, then let the scan finish
    task automatic wait_until_idle();
        sample_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_windows.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // setup cycle then access cycle; the leading edge keeps psel from toggling in one step
    task automatic apb_transfer(input logic write, input logic index,
                                input logic [APB_DATA_W-1:0] data,
                                output logic [APB_DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_target();
        logic [APB_DATA_W-1:0] rd;
        apb_transfer(1'b0, REG_TARGET, '0, rd);
        if (rd !== APB_DATA_W'(target_now)) begin
            $error("target_sum readback expected %0d actual %0d", target_now, rd);
            fail_count++;
        end
    endtask

    task automatic set_register(input logic index, input logic [APB_DATA_W-1:0] data);
        logic [APB_DATA_W-1:0] rd;
        apb_transfer(1'b1, index, data, rd);
        if (index == REG_TARGET) target_now = data[TARGET_W-1:0];
        check_target();
    endtask

    task automatic run_random_phase(input logic [TARGET_W-1:0] target);
        wait_until_idle();
        // junk in the upper data bits must be dropped
        set_register(REG_TARGET, {APB_DATA_W'($urandom()) >> TARGET_W << TARGET_W} | target);
        repeat (PHASE_ITEMS) feed_sample(pick_value(target), $urandom_range(0, 19) == 0);
    endtask

    // receiver: the stall pattern is drawn anew for each random stretch
    t_sink_mode sink_mode = SINK_OPEN;
    int         sink_left = 0;

    always @(posedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode = t_sink_mode'($urandom_range(0, 3));
            sink_left = $urandom_range(8, 60);
        end
        sink_left--;
        case (sink_mode)
            SINK_OPEN:   result_tready <= 1'b1;
            SINK_COIN:   result_tready <= 1'($urandom_range(0, 1));
            SINK_SPARSE: result_tready <= ($urandom_range(0, 3) == 0);
            default:     result_tready <= 1'b0;
        endcase
    end

    // result checker and activity counter for the watchdog
    always @(posedge i_clk) begin : result_check
        t_window want;
        if ((sample_tvalid && sample_tready) || (result_tvalid && result_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (i_rst_n && result_tvalid && result_tready) begin
            if (expected_windows.size() == 0) begin
                $error("result beat with nothing expected: start %0d end %0d",
                       result_tdata[15:0], result_tdata[31:16]);
                fail_count++;
            end else begin
                want = expected_windows.pop_front();
                if (result_tdata[15:0] !== want.win_start) begin
                    $error("window_start expected %0d actual %0d",
                           want.win_start, result_tdata[15:0]);
                    fail_count++;
                end
                if (result_tdata[31:16] !== want.win_end) begin
                    $error("window_end expected %0d actual %0d",
                           want.win_end, result_tdata[31:16]);
                    fail_count++;
                end
                if (result_tlast !== want.run_last) begin
                    $error("last_of_run expected %0d actual %0d", want.run_last, result_tlast);
                    fail_count++;
                end
                if (result_tuser[0] !== want.lost) begin
                    $error("windows_lost expected %0d actual %0d", want.lost, result_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // target must come up at its reset value
        check_target();

        // directed table
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_WRITE) begin
                wait_until_idle();
                set_register(directed_rows[r].reg_index, directed_rows[r].reg_data);
            end else begin
                send_sample(directed_rows[r].kind, directed_rows[r].value, directed_rows[r].eos,
                            directed_rows[r].exp_start, directed_rows[r].exp_end);
            end
        end

        // random phases, flag still clear
        run_random_phase(12'd10);
        run_random_phase(TARGET_W'($urandom_range(1, 30)));
        run_random_phase(12'd0);
        run_random_phase(TARGET_W'($urandom_range(31, 300)));

        // every cell matching on one sample, then the row overflowing
        wait_until_idle();
        set_register(REG_TARGET, 32'd10);
        feed_sample(8'hFF, 1'b1);
        repeat (OPEN_WINDOWS - 1) feed_sample(8'd0, 1'b0);
        feed_sample(8'd10, 1'b0);
        repeat (OPEN_WINDOWS + 1) feed_sample(8'd0, 1'b0);
        feed_sample(8'd10, 1'b0);
        feed_sample(8'd1, 1'b1);

        // random phases with the sticky flag set
        run_random_phase(12'd4095);
        run_random_phase(TARGET_W'($urandom_range(1, 15)));
        run_random_phase(TARGET_W'($urandom_range(300, 2000)));
        run_random_phase(12'd1);

        wait_until_idle();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
